// ===== sv/hill_cipher_2x2_mod26_macros.svh =====
// assertion macros for the hill cipher block
`ifndef HILL_CIPHER_2X2_MOD26_MACROS_SVH
`define HILL_CIPHER_2X2_MOD26_MACROS_SVH

// same-cycle implication, checked outside reset
`define HC2_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hill cipher check failed");

// next-cycle implication, checked outside reset
`define HC2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hill cipher check failed");

`endif

// ===== sv/hc2_pkg.sv =====
// shared types, constants and mod 26 helpers for the hill cipher block
package hc2_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned WIDE_W = 11;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [WIDE_W-1:0] wide_t;

  localparam letter_t MODULUS = 5'd26;
  localparam letter_t PAD_LETTER = 5'd23;
  localparam letter_t NEG_ONE = 5'd25;
  localparam wide_t MOD_SQ = 11'd676;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R0C0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R0C1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R1C0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_R1C1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_ADJ,
    ST_MUL,
    ST_OUT0,
    ST_OUT1
  } state_t;

  typedef struct packed {
    logic hold_ld;
    logic pair_ld;
    logic use_held;
    logic det_en;
    logic mat_en;
    logic mul_en;
    logic sel_second;
  } hc2_cmd_t;

  // reduce a 5-bit value into 0..25
  function automatic letter_t mod26_small(letter_t v);
    letter_t r;
    r = (v >= MODULUS) ? v - MODULUS : v;
    return r;
  endfunction

  // reduce a value below 2048 into 0..25 by reciprocal multiply
  function automatic letter_t mod26_wide(wide_t v);
    logic [23:0] prod;
    logic [12:0] q;
    logic [12:0] rem;
    prod = {13'd0, v} * 24'd2521;
    q = {5'd0, prod[23:16]};
    rem = {2'd0, v} - q * 13'd26;
    return rem[LETTER_W-1:0];
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic letter_t inv26(letter_t d);
    letter_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/hc2_ctrl.sv =====
// controller state machine: pairing, compute sequencing and output handshake
module hc2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_end_of_text,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_last_of_pair,
  output hc2_pkg::hc2_cmd_t cmd
);
  import hc2_pkg::*;

  state_t state_r, state_nxt;
  logic   holding_r, holding_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      holding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      holding_r <= holding_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    holding_nxt      = holding_r;
    cmd              = '0;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    out_last_of_pair = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!holding_r && !in_end_of_text) begin
            cmd.hold_ld = 1'b1;
            holding_nxt = 1'b1;
          end else begin
            cmd.pair_ld  = 1'b1;
            cmd.use_held = holding_r;
            holding_nxt  = 1'b0;
            state_nxt    = ST_DET;
          end
        end
      end
      ST_DET: begin
        cmd.det_en = 1'b1;
        state_nxt  = ST_ADJ;
      end
      ST_ADJ: begin
        cmd.mat_en = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_OUT0;
      end
      ST_OUT0: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_OUT1;
        end
      end
      ST_OUT1: begin
        out_valid        = 1'b1;
        out_last_of_pair = 1'b1;
        cmd.sel_second   = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/hc2_dp.sv =====
// datapath: key registers, pair registers, key inversion and matrix multiply
module hc2_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [hc2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hc2_pkg::LETTER_W-1:0]      cfg_wdata,
  input  logic [hc2_pkg::LETTER_W-1:0]      in_letter_in,
  input  hc2_pkg::hc2_cmd_t                 cmd,
  output logic [hc2_pkg::LETTER_W-1:0]      out_letter_out,
  output logic                              out_key_error
);
  import hc2_pkg::*;

  letter_t key00_r, key01_r, key10_r, key11_r;
  logic    dec_r;
  letter_t held_r;
  letter_t p0_r, p1_r;
  letter_t km00_r, km01_r, km10_r, km11_r;
  letter_t det_r;
  letter_t m00_r, m01_r, m10_r, m11_r;
  logic    err_r;
  letter_t c0_r, c1_r;

  letter_t       letter_red;
  logic [9:0]    det_pa, det_pb;
  letter_t       det_nxt;
  letter_t       inv, mult;
  letter_t       adj01, adj10;
  logic [9:0]    q00, q01, q10, q11;
  logic [9:0]    t00, t01, t10, t11;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key00_r <= 5'd3;
      key01_r <= 5'd3;
      key10_r <= 5'd2;
      key11_r <= 5'd5;
      dec_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_R0C0: key00_r <= cfg_wdata;
        CFG_KEY_R0C1: key01_r <= cfg_wdata;
        CFG_KEY_R1C0: key10_r <= cfg_wdata;
        CFG_KEY_R1C1: key11_r <= cfg_wdata;
        CFG_DECRYPT:  dec_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign letter_red = mod26_small(in_letter_in);

  // determinant of the reduced key
  assign det_pa  = {5'd0, km00_r} * {5'd0, km11_r};
  assign det_pb  = {5'd0, km01_r} * {5'd0, km10_r};
  assign det_nxt = mod26_wide(wide_t'(det_pa) + MOD_SQ - wide_t'(det_pb));

  // adjugate scaled by the inverse determinant
  assign inv   = inv26(det_r);
  assign mult  = (inv == '0) ? NEG_ONE : inv;
  assign adj01 = (km01_r == '0) ? '0 : MODULUS - km01_r;
  assign adj10 = (km10_r == '0) ? '0 : MODULUS - km10_r;
  assign q00   = {5'd0, km11_r} * {5'd0, mult};
  assign q01   = {5'd0, adj01} * {5'd0, mult};
  assign q10   = {5'd0, adj10} * {5'd0, mult};
  assign q11   = {5'd0, km00_r} * {5'd0, mult};

  // matrix times pair
  assign t00 = {5'd0, m00_r} * {5'd0, p0_r};
  assign t01 = {5'd0, m01_r} * {5'd0, p1_r};
  assign t10 = {5'd0, m10_r} * {5'd0, p0_r};
  assign t11 = {5'd0, m11_r} * {5'd0, p1_r};

  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      held_r <= letter_red;
    end
    if (cmd.pair_ld) begin
      p0_r   <= cmd.use_held ? held_r : letter_red;
      p1_r   <= cmd.use_held ? letter_red : PAD_LETTER;
      km00_r <= mod26_small(key00_r);
      km01_r <= mod26_small(key01_r);
      km10_r <= mod26_small(key10_r);
      km11_r <= mod26_small(key11_r);
    end
    if (cmd.det_en) begin
      det_r <= det_nxt;
    end
    if (cmd.mat_en) begin
      if (dec_r) begin
        m00_r <= mod26_wide(wide_t'(q00));
        m01_r <= mod26_wide(wide_t'(q01));
        m10_r <= mod26_wide(wide_t'(q10));
        m11_r <= mod26_wide(wide_t'(q11));
        err_r <= (inv == '0);
      end else begin
        m00_r <= km00_r;
        m01_r <= km01_r;
        m10_r <= km10_r;
        m11_r <= km11_r;
        err_r <= 1'b0;
      end
    end
    if (cmd.mul_en) begin
      c0_r <= mod26_wide(wide_t'(t00) + wide_t'(t01));
      c1_r <= mod26_wide(wide_t'(t10) + wide_t'(t11));
    end
  end

  assign out_letter_out = cmd.sel_second ? c1_r : c0_r;
  assign out_key_error  = err_r;

endmodule

// ===== sv/hill_cipher_2x2_mod26.sv =====
// top level of the 2x2 mod 26 hill cipher
//
// input channel: in_valid, in_stall, in_letter_in (0..25), in_end_of_text.
// letters are paired; the first letter of a pair is held with no output.
// a letter with end_of_text and no open pair is paired with X (23).
// result channel: out_valid, out_stall, out_letter_out, out_last_of_pair,
// out_key_error; each completed pair gives two items, the second flagged
// by out_last_of_pair. key_error is set in decrypt mode when the key
// determinant has no inverse mod 26.
// configuration: cfg_wr_en, cfg_index, cfg_wdata; write only while idle.
// sequence: the first output item is valid once the states ST_DET, ST_ADJ
// and ST_MUL have passed after the letter that completes a pair is taken; the
// second follows in the cycle after the first is taken. a held letter is only stored.
// pacing: the sequencer steps determinant, inversion and multiply one per
// cycle and then emits two items; a new letter is taken only when idle, so
// both items of a pair are taken before the next letter is taken.
// reset: key 3,3,2,5, encrypt mode, no open pair, no output valid.
// stall: a stalled output item holds; input stays stalled until both
// items of the pair are taken.
module hill_cipher_2x2_mod26 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hc2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hc2_pkg::LETTER_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hc2_pkg::LETTER_W-1:0]  in_letter_in,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hc2_pkg::LETTER_W-1:0]  out_letter_out,
  output logic                          out_last_of_pair,
  output logic                          out_key_error
);
  import hc2_pkg::*;

  `include "hill_cipher_2x2_mod26_macros.svh"

  hc2_cmd_t cmd;

  hc2_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_end_of_text   (in_end_of_text),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_last_of_pair (out_last_of_pair),
    .cmd              (cmd)
  );

  hc2_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_letter_in   (in_letter_in),
    .cmd            (cmd),
    .out_letter_out (out_letter_out),
    .out_key_error  (out_key_error)
  );

  `HC2_ASSERT_NOW(a_no_intake_while_output, !in_stall, !out_valid)
  `HC2_ASSERT_NEXT(a_second_follows_first, out_valid && !out_stall && !out_last_of_pair,
                   out_valid && out_last_of_pair)
  `HC2_ASSERT_NEXT(a_idle_after_pair, out_valid && !out_stall && out_last_of_pair,
                   !out_valid && !in_stall)

endmodule
